// ===== hdl/l1_nearest_neighbor_classifier_unit_defines.svh =====
// assertion macros for the l1 nearest neighbor classifier unit
// the using module supplies clk and arst_n in its scope
`ifndef L1_NEAREST_NEIGHBOR_CLASSIFIER_UNIT_DEFINES_SVH
`define L1_NEAREST_NEIGHBOR_CLASSIFIER_UNIT_DEFINES_SVH

// checked only outside reset
`define L1NN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define L1NN_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/l1nn_pkg.sv =====
// shared types, constants and helpers of the l1 nearest neighbor classifier
// no dependencies
package l1nn_pkg;

	localparam int VALUE_W = 16;
	localparam int SUM_W   = 21;
	localparam int DIST_W  = 20;

	localparam logic CMD_LOAD     = 1'b0;
	localparam logic CMD_CLASSIFY = 1'b1;

	localparam logic [SUM_W-1:0]  SUM_MAX      = 21'h1FFFFF;
	localparam logic [DIST_W-1:0] DIST_OUT_MAX = 20'hFFFFF;
	// no class has won yet; a strict compare keeps class 0 on a saturated sum
	localparam logic [SUM_W-1:0]  DIST_INIT    = 21'h1FFFFF;

	// request token that walks the row of class cells
	typedef struct packed {
		logic                       valid;
		logic                       last;
		logic signed [VALUE_W-1:0]  value;
		logic [SUM_W-1:0]           run_min;
	} token_t;

	// exact |a - b| of two signed 16-bit values
	function automatic logic [VALUE_W:0] abs_diff17(logic [VALUE_W-1:0] a,
			logic [VALUE_W-1:0] b);
		logic [VALUE_W:0] d;
		d = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
		return d[VALUE_W] ? (~d + 17'd1) : d;
	endfunction

endpackage

// ===== hdl/l1nn_req_if.sv =====
// request channel of the l1 nearest neighbor classifier
// valid/ready handshake with the request fields; no dependencies
interface l1nn_req_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic [2:0]         class_index;
	logic [3:0]         feature_index;
	logic signed [15:0] value;

	modport source (output valid, command, class_index, feature_index, value, input ready);
	modport sink   (input valid, command, class_index, feature_index, value, output ready);
endinterface

// ===== hdl/l1nn_rsp_if.sv =====
// result channel of the l1 nearest neighbor classifier
// valid/ready handshake with the result fields; no dependencies
interface l1nn_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  best_class;
	logic [19:0] best_distance;

	modport source (output valid, best_class, best_distance, input ready);
	modport sink   (input valid, best_class, best_distance, output ready);
endinterface

// ===== hdl/l1nn_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module l1nn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== hdl/l1nn_cell.sv =====
// one class cell: reference vector, running distance sum, min-compare stage
// depends on l1nn_pkg and l1nn_ram
module l1nn_cell #(
	parameter int NUM_FEATURES = 16,
	parameter int IDX_W        = 3,
	parameter int CELL_INDEX   = 0,
	parameter int FEAT_AW      = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic                  rd_en,
	input  logic [FEAT_AW-1:0]    addr,
	input  logic [15:0]           wr_data,
	input  l1nn_pkg::token_t      tok_in,
	input  logic [IDX_W-1:0]      idx_in,
	output l1nn_pkg::token_t      tok_out,
	output logic [IDX_W-1:0]      idx_out
);
	import l1nn_pkg::*;

	logic [VALUE_W-1:0]        ref_val;
	logic [VALUE_W:0]          absd;
	logic [SUM_W:0]            sum_wide;
	logic [SUM_W-1:0]          sum_sat;
	logic [SUM_W-1:0]          sum_q;
	logic                      better;
	logic                      valid_q;
	logic                      last_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [SUM_W-1:0]          run_min_q;
	logic [IDX_W-1:0]          idx_q;

	l1nn_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (NUM_FEATURES),
		.AW    (FEAT_AW)
	) u_ref (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (addr),
		.rdata (ref_val)
	);

	// the reference word was read when the request was taken and holds until the token arrives
	always_comb begin
		absd     = abs_diff17(tok_in.value, ref_val);
		sum_wide = {1'b0, sum_q} + (SUM_W + 1)'(absd);
		sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
		better   = sum_sat < tok_in.run_min;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
			if (tok_in.valid) begin
				sum_q <= tok_in.last ? '0 : sum_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		value_q <= tok_in.value;
		last_q  <= tok_in.last;
		if (tok_in.last && better) begin
			run_min_q <= sum_sat;
			idx_q     <= IDX_W'(CELL_INDEX);
		end else begin
			run_min_q <= tok_in.run_min;
			idx_q     <= idx_in;
		end
	end

	always_comb begin
		tok_out.valid   = valid_q;
		tok_out.last    = last_q;
		tok_out.value   = value_q;
		tok_out.run_min = run_min_q;
	end

	assign idx_out = idx_q;
endmodule

// ===== hdl/l1_nearest_neighbor_classifier_unit.sv =====
// top level of the l1 nearest neighbor classifier: request decode, row of class cells,
// result skid buffer; depends on l1nn_pkg, l1nn_req_if, l1nn_rsp_if, l1nn_cell
//
// usage
//   req carries load and classify requests, rsp carries results; both are valid/ready.
//   a load (command 0) writes one reference element into the cell of its class;
//   loads may come back to back.
//   a classify (command 1) reads the reference word at its feature index in every
//   cell at once, then a token walks the row of NUM_CLASSES cells, one per cycle,
//   each cell adding its absolute difference to its class sum. on the top feature
//   index the token also carries the running minimum and the sums clear.
//   a classify occupies the row until its token leaves the last cell and holds
//   req.ready low meanwhile; its result passes the entry stage and every cell
//   register, and is registered into the output register as the token leaves the row.
//   requests out of range are taken and dropped.
//   a stalled result sits in the output register while new requests are taken; a
//   second finished result waits in a skid register and holds req.ready low.
//   reset clears the sums and all valid flags; reference entries stay undefined
//   until loaded.
module l1_nearest_neighbor_classifier_unit #(
	parameter int NUM_CLASSES  = 8,
	parameter int NUM_FEATURES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	l1nn_req_if.sink    req,
	l1nn_rsp_if.source  rsp
);
	import l1nn_pkg::*;
	`include "l1_nearest_neighbor_classifier_unit_defines.svh"

	localparam int IDX_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int FEAT_AW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

	logic               feat_ok;
	logic               cls_ok;
	logic               feat_last;
	logic               acc;
	logic               acc_load;
	logic               acc_cls;
	logic [FEAT_AW-1:0] addr;
	logic               busy_q;
	logic               fin;
	logic               out_free;
	logic               out_valid_q;
	logic               pend_valid_q;
	logic [2:0]         out_class_q;
	logic [DIST_W-1:0]  out_dist_q;
	logic [2:0]         pend_class_q;
	logic [DIST_W-1:0]  pend_dist_q;
	logic [2:0]         tail_class;
	logic [DIST_W-1:0]  tail_dist;
	logic               entry_valid_q;
	logic               entry_last_q;
	logic signed [VALUE_W-1:0] entry_value_q;

	token_t             tok  [NUM_CLASSES+1];
	logic [IDX_W-1:0]   idx  [NUM_CLASSES+1];
	logic [NUM_CLASSES-1:0] wr_en;

	assign feat_ok   = 32'(req.feature_index) < NUM_FEATURES;
	assign cls_ok    = 32'(req.class_index) < NUM_CLASSES;
	assign feat_last = 32'(req.feature_index) == NUM_FEATURES - 1;
	assign addr      = FEAT_AW'(req.feature_index);

	assign req.ready = !busy_q && !pend_valid_q;
	assign acc       = req.valid && req.ready;
	assign acc_load  = acc && feat_ok && cls_ok && (req.command == CMD_LOAD);
	assign acc_cls   = acc && feat_ok && (req.command == CMD_CLASSIFY);

	// entry stage of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= 1'b0;
		end else begin
			entry_valid_q <= acc_cls;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_cls) begin
			entry_value_q <= req.value;
			entry_last_q  <= feat_last;
		end
	end

	always_comb begin
		tok[0].valid   = entry_valid_q;
		tok[0].last    = entry_last_q;
		tok[0].value   = entry_value_q;
		tok[0].run_min = DIST_INIT;
		idx[0]         = '0;
	end

	for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_cell
		assign wr_en[k] = acc_load && (32'(req.class_index) == k);

		l1nn_cell #(
			.NUM_FEATURES (NUM_FEATURES),
			.IDX_W        (IDX_W),
			.CELL_INDEX   (k),
			.FEAT_AW      (FEAT_AW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (wr_en[k]),
			.rd_en   (acc_cls),
			.addr    (addr),
			.wr_data (req.value),
			.tok_in  (tok[k]),
			.idx_in  (idx[k]),
			.tok_out (tok[k+1]),
			.idx_out (idx[k+1])
		);
	end

	assign fin        = tok[NUM_CLASSES].valid && tok[NUM_CLASSES].last;
	assign tail_class = 3'(idx[NUM_CLASSES]);
	assign tail_dist  = (tok[NUM_CLASSES].run_min > SUM_W'(DIST_OUT_MAX)) ? DIST_OUT_MAX
		: tok[NUM_CLASSES].run_min[DIST_W-1:0];
	assign out_free   = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (acc_cls) begin
				busy_q <= 1'b1;
			end else if (tok[NUM_CLASSES].valid) begin
				busy_q <= 1'b0;
			end
			if (out_free) begin
				if (pend_valid_q) begin
					out_valid_q  <= 1'b1;
					pend_valid_q <= 1'b0;
				end else begin
					out_valid_q <= fin;
				end
			end else if (fin) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				out_class_q <= pend_class_q;
				out_dist_q  <= pend_dist_q;
			end else if (fin) begin
				out_class_q <= tail_class;
				out_dist_q  <= tail_dist;
			end
		end else if (fin) begin
			pend_class_q <= tail_class;
			pend_dist_q  <= tail_dist;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.best_class    = out_class_q;
	assign rsp.best_distance = out_dist_q;

	`L1NN_ASSERT(a_result_source, $rose(out_valid_q) |-> $past(fin) || $past(pend_valid_q), "result without a finished token")
	`L1NN_ASSERT_ALWAYS(a_skid_behind_out, !pend_valid_q || out_valid_q, "skid register filled while output register empty")
	`L1NN_ASSERT(a_token_while_busy, tok[NUM_CLASSES].valid |-> busy_q, "token left the row while not busy")
	`L1NN_ASSERT(a_classify_sets_busy, acc_cls |=> busy_q && !req.ready, "classify request did not occupy the row")
endmodule
